// File: rtl/windowed_median_null_skip_defines.svh
// ----------------------------------------------------------------------------
// windowed_median_null_skip_defines
// assertion macros used by the median filter top level
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEDIAN_NULL_SKIP_DEFINES_SVH
`define WINDOWED_MEDIAN_NULL_SKIP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define WMNS_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define WMNS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wmns_pkg.sv
// ----------------------------------------------------------------------------
// wmns_pkg
// shared constants and types of the windowed median filter
// ----------------------------------------------------------------------------
package wmns_pkg;

   // window geometry
   localparam int MAX_HALF    = 15;
   localparam int SAMPLE_BITS = 32;
   localparam int HALF_W      = 4;
   localparam int DEPTH       = 2 * MAX_HALF + 1;
   localparam int AGE_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // command broadcast to every sort cell
   typedef struct packed {
      logic       clear;
      logic       insert;
      sample_type key;
   } sort_cmd_type;

   // what a cell hands to its right-hand neighbor
   typedef struct packed {
      logic       lt;
      logic       valid;
      sample_type value;
   } cell_link_type;

endpackage

// File: rtl/wmns_sort_cell.sv
// ----------------------------------------------------------------------------
// wmns_sort_cell
// one slot of the sorted insertion chain
// ----------------------------------------------------------------------------
module wmns_sort_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  wmns_pkg::sort_cmd_type  cmd,
   input  wmns_pkg::cell_link_type prev,
   output wmns_pkg::cell_link_type link
);
   import wmns_pkg::*;

   sample_type value_ff;
   sample_type value_in;
   logic       valid_ff;
   logic       valid_in;
   logic       lt;

   // an empty slot sorts as larger than any key
   assign lt = !valid_ff || ($signed(cmd.key) < $signed(value_ff));

   // take the key, or the left neighbor's entry when the key lands further left
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert && lt) begin
         if (prev.lt) begin
            value_in = prev.value;
            valid_in = prev.valid;
         end else begin
            value_in = cmd.key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link = '{lt: lt, valid: valid_ff, value: value_ff};

endmodule

// File: rtl/wmns_sort_chain.sv
// ----------------------------------------------------------------------------
// wmns_sort_chain
// row of sort cells with an entry count and a median tap
// ----------------------------------------------------------------------------
module wmns_sort_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  wmns_pkg::sort_cmd_type cmd,
   output wmns_pkg::sample_type   median_value,
   output logic                   median_empty
);
   import wmns_pkg::*;

   cell_link_type              links [DEPTH];
   logic          [CNT_W-1:0]  count_ff;
   logic          [AGE_W-1:0]  mid_idx;

   // cells, each fed by its left neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type prev_link;
      if (i == 0) begin : g_head
         assign prev_link = '0;
      end else begin : g_body
         assign prev_link = links[i-1];
      end
      wmns_sort_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .prev  (prev_link),
         .link  (links[i])
      );
   end

   // number of keys held
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // upper median sits at index count/2
   assign mid_idx      = AGE_W'(count_ff >> 1);
   assign median_empty = (count_ff == '0);
   assign median_value = median_empty ? '0 : links[mid_idx].value;

endmodule

// File: rtl/wmns_window.sv
// ----------------------------------------------------------------------------
// wmns_window
// shift line of the most recent samples, newest at age zero
// ----------------------------------------------------------------------------
module wmns_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift,
   input  logic                           clear,
   input  wmns_pkg::sample_type           in_value,
   input  logic                           in_valid,
   input  logic [wmns_pkg::AGE_W-1:0]     rd_age,
   output wmns_pkg::sample_type           rd_value,
   output logic                           rd_valid
);
   import wmns_pkg::*;

   sample_type value_ff [DEPTH];
   logic       valid_ff [DEPTH];

   // valid bits, cleared at reset and at record end
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (shift) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // sample values
   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff[0] <= in_value;
         for (int i = 1; i < DEPTH; i++) begin
            value_ff[i] <= value_ff[i-1];
         end
      end
   end

   assign rd_value = value_ff[rd_age];
   assign rd_valid = valid_ff[rd_age];

endmodule

// File: rtl/windowed_median_null_skip.sv
// ----------------------------------------------------------------------------
// windowed_median_null_skip
// sliding window median over one record, null samples skipped
//
// usage:
// req_ carries one sample item per handshake (valid high, stall low): value,
// null flag and record_last. rsp_ returns result items the same way; the
// block holds a result steady while rsp_stall is high. csr_ writes
// half_length H (window 2*H+1) and is always ready; write it between records.
// result p appears once sample p+H has arrived; record_last flushes the
// remaining results, at most H+1, and clears the sample history.
// each result feeds window entries 0..hi into the sort chain, one per cycle,
// hi = min(d+H, 30) for output offset d (d = H before record end), then a
// pick step registers the median as the result. an early item of a record
// that releases no result leaves the block idle; record_last walks through
// its flushed results in turn, oldest first.
// the input is stalled from the accept until the last result of that item is
// taken. reset (synchronous) empties the history and sets H to zero.
// ----------------------------------------------------------------------------
`include "windowed_median_null_skip_defines.svh"

module windowed_median_null_skip (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_sample_value,
   input  logic                              req_sample_is_null,
   input  logic                              req_record_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_median_value,
   output logic                              rsp_median_is_null,
   output logic                              rsp_result_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wmns_pkg::HALF_W-1:0]       csr_half_length
);
   import wmns_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PICK,
      ST_OUT
   } state_type;

   state_type              state_ff;
   logic [HALF_W-1:0]      half_ff;
   logic [CNT_W-1:0]       seen_ff;
   logic [AGE_W-1:0]       age_ff;
   logic [AGE_W-1:0]       hi_ff;
   logic [AGE_W-1:0]       d_ff;
   logic                   flush_ff;
   logic                   rsp_valid_ff;
   sample_type             rsp_value_ff;
   logic                   rsp_null_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   rsp_take;
   logic [AGE_W-1:0]       h_eff;
   logic [CNT_W-1:0]       count_now;
   logic [AGE_W-1:0]       top_age;
   logic [AGE_W-1:0]       first_d;
   logic                   emit_now;
   logic                   win_clear;
   sample_type             in_value;
   sample_type             rd_value;
   logic                   rd_valid;
   sort_cmd_type           cmd;
   sample_type             median_value;
   logic                   median_empty;

   // last age of the window around offset d
   function automatic logic [AGE_W-1:0] hi_for(input logic [AGE_W-1:0] d,
                                                input logic [AGE_W-1:0] h);
      logic [AGE_W:0] sum;
      sum = {1'b0, d} + {1'b0, h};
      if (sum > (AGE_W+1)'(DEPTH - 1)) begin
         return AGE_W'(DEPTH - 1);
      end
      return sum[AGE_W-1:0];
   endfunction

   assign accept   = req_valid && !req_stall;
   assign rsp_take = (state_ff == ST_OUT) && !rsp_stall;
   assign csr_ready = 1'b1;

   // half length, clamped to MAX_HALF
   assign h_eff = (int'(half_ff) > MAX_HALF) ? AGE_W'(MAX_HALF) : AGE_W'(half_ff);

   // samples of this record including the one arriving now, capped at DEPTH
   assign count_now = (int'(seen_ff) >= DEPTH) ? seen_ff : seen_ff + CNT_W'(1);
   assign top_age   = AGE_W'(count_now - CNT_W'(1));
   // first result sits H back, or at the oldest owed position on a flush
   assign first_d   = !req_record_last ? h_eff : ((h_eff > top_age) ? top_age : h_eff);
   assign emit_now  = req_record_last || (count_now > CNT_W'(h_eff));

   // history is dropped once the final result of a record leaves
   assign win_clear = rsp_take && flush_ff && (d_ff == '0);

   assign in_value = req_sample_is_null ? '0 : sample_type'(req_sample_value);

   wmns_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift    (accept),
      .clear    (win_clear),
      .in_value (in_value),
      .in_valid (!req_sample_is_null),
      .rd_age   (age_ff),
      .rd_value (rd_value),
      .rd_valid (rd_valid)
   );

   // chain is emptied before each result and fed one window entry a cycle
   always_comb begin
      cmd.clear  = accept || rsp_take;
      cmd.insert = (state_ff == ST_LOAD) && rd_valid;
      cmd.key    = rd_value;
   end

   wmns_sort_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .median_value (median_value),
      .median_empty (median_empty)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         half_ff <= csr_half_length;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         age_ff       <= '0;
         hi_ff        <= '0;
         d_ff         <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_value_ff <= '0;
         rsp_null_ff  <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  seen_ff  <= count_now;
                  flush_ff <= req_record_last;
                  d_ff     <= first_d;
                  hi_ff    <= hi_for(first_d, h_eff);
                  age_ff   <= '0;
                  if (emit_now) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               if (age_ff == hi_ff) begin
                  state_ff <= ST_PICK;
               end else begin
                  age_ff <= age_ff + AGE_W'(1);
               end
            end
            ST_PICK: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= median_value;
               rsp_null_ff  <= median_empty;
               rsp_last_ff  <= flush_ff && (d_ff == '0);
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (flush_ff && (d_ff != '0)) begin
                     d_ff     <= d_ff - AGE_W'(1);
                     hi_ff    <= hi_for(d_ff - AGE_W'(1), h_eff);
                     age_ff   <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     if (flush_ff) begin
                        seen_ff <= '0;
                     end
                     flush_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_value   = rsp_value_ff;
   assign rsp_median_is_null = rsp_null_ff;
   assign rsp_result_last    = rsp_last_ff;

   // checks
   `WMNS_IMPLY(a_load_in_window, state_ff == ST_LOAD, age_ff <= hi_ff, "window read past its end")
   `WMNS_IMPLY(a_busy_while_out, rsp_valid_ff, req_stall, "input open while a result waits")
   `WMNS_NEXT(a_flush_resets, win_clear, seen_ff == '0, "sample count kept after record end")
   `WMNS_IMPLY(a_last_only_flush, rsp_valid_ff && rsp_last_ff, flush_ff, "last result outside flush")

endmodule

// File: sim/wmns_median_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmns_median_checker
// watches the sample, result and register channels of the median filter,
// keeps its own sample history and half length, predicts every result item
// and compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module wmns_median_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [31:0]            req_sample_value,
   input  logic                          req_sample_is_null,
   input  logic                          req_record_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [31:0]            rsp_median_value,
   input  logic                          rsp_median_is_null,
   input  logic                          rsp_result_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [wmns_pkg::HALF_W-1:0]   csr_half_length,
   output int                            error_count,
   output int                            pending_count
);
   import wmns_pkg::*;

   typedef struct {
      sample_type value;
      logic       is_null;
      logic       last;
   } median_result_type;

   // sample history, age 0 is the newest sample
   sample_type        hist_value [DEPTH];
   logic              hist_ok    [DEPTH];
   int                hist_count;
   logic [HALF_W-1:0] half_len;

   median_result_type pending_medians [$];

   // forget the record seen so far
   task automatic clear_history();
      for (int a = 0; a < DEPTH; a++) begin
         hist_value[a] = '0;
         hist_ok[a]    = 1'b0;
      end
      hist_count = 0;
   endtask

   // upper median of the non-null samples at ages lo..hi
   function automatic median_result_type window_median(input int lo, input int hi,
                                                       input logic last);
      sample_type        sorted [DEPTH];
      int                n;
      int                j;
      median_result_type m;
      n = 0;
      for (int a = lo; a <= hi && a < DEPTH; a++) begin
         if (hist_ok[a]) begin
            j = n;
            while (j > 0 && sorted[j-1] > hist_value[a]) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = hist_value[a];
            n++;
         end
      end
      if (n > 0) begin
         m.value   = sorted[n/2];
         m.is_null = 1'b0;
      end else begin
         m.value   = '0;
         m.is_null = 1'b1;
      end
      m.last = last;
      return m;
   endfunction

   // shift one sample in and queue the results it releases
   task automatic take_sample(input sample_type value, input logic is_null,
                              input logic last);
      int count;
      int top;
      int h;
      int hi;
      for (int a = DEPTH - 1; a > 0; a--) begin
         hist_value[a] = hist_value[a-1];
         hist_ok[a]    = hist_ok[a-1];
      end
      hist_value[0] = is_null ? sample_type'(0) : value;
      hist_ok[0]    = !is_null;

      h     = (half_len > MAX_HALF) ? MAX_HALF : int'(half_len);
      count = (hist_count + 1 > DEPTH) ? DEPTH : hist_count + 1;
      top   = count - 1;

      if (!last) begin
         if (count > h) begin
            hi = (2 * h > top) ? top : 2 * h;
            pending_medians.insert(pending_medians.size(), window_median(0, hi, 1'b0));
         end
         hist_count = count;
      end else begin
         // flush: one result per position still owed, oldest first
         for (int d = h; d >= 0; d--) begin
            if (d <= top) begin
               hi = (d + h > top) ? top : d + h;
               pending_medians.insert(pending_medians.size(),
                                      window_median(0, hi, d == 0));
            end
         end
         clear_history();
      end
   endtask

   always @(posedge clock) begin : watch
      median_result_type want;
      logic              bad;
      if (reset) begin
         clear_history();
         half_len = '0;
         pending_medians.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            half_len = csr_half_length;
         end

         // compare an accepted result item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_medians.size() == 0) begin
               $display("%0t: unexpected result: expected none, got %0d null %0b last %0b",
                        $time, rsp_median_value, rsp_median_is_null, rsp_result_last);
               error_count++;
            end else begin
               want = pending_medians.pop_front();
               bad  = 1'b0;
               if (rsp_median_value !== want.value) begin
                  $display("%0t: median_value expected %0d, got %0d",
                           $time, want.value, rsp_median_value);
                  bad = 1'b1;
               end
               if (rsp_median_is_null !== want.is_null) begin
                  $display("%0t: median_is_null expected %0b, got %0b",
                           $time, want.is_null, rsp_median_is_null);
                  bad = 1'b1;
               end
               if (rsp_result_last !== want.last) begin
                  $display("%0t: result_last expected %0b, got %0b",
                           $time, want.last, rsp_result_last);
                  bad = 1'b1;
               end
               if (bad) begin
                  error_count++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            take_sample(req_sample_value, req_sample_is_null, req_record_last);
         end
      end
      pending_count <= pending_medians.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the windowed median filter: directed records over the field
// extremes, null windows, short records and a mid-record half length change,
// then random records under several half lengths with random idling on both
// sides and one long receiver hold-off; checking is done by the checker
// ----------------------------------------------------------------------------
module tb;
   import wmns_pkg::*;

   localparam int RANDOM_ITEMS     = 430;
   localparam int CALM_ITEMS       = 60;
   localparam int DRAIN_CYCLES     = 2 * MAX_HALF + 10;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 2000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_sample_value;
   logic               req_sample_is_null;
   logic               req_record_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_median_value;
   logic               rsp_median_is_null;
   logic               rsp_result_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [HALF_W-1:0]  csr_half_length;

   int                 error_count;
   int                 pending_count;
   int                 sent_count;
   int                 calm_from;
   bit                 calm;
   int unsigned        cycle_count = 0;

   windowed_median_null_skip dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .req_sample_is_null (req_sample_is_null),
      .req_record_last    (req_record_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median_value   (rsp_median_value),
      .rsp_median_is_null (rsp_median_is_null),
      .rsp_result_last    (rsp_result_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_half_length    (csr_half_length)
   );

   wmns_median_checker median_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .req_sample_is_null (req_sample_is_null),
      .req_record_last    (req_record_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median_value   (rsp_median_value),
      .rsp_median_is_null (rsp_median_is_null),
      .rsp_result_last    (rsp_result_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_half_length    (csr_half_length),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // offer one sample item, with an optional idle burst first
   task automatic send_sample(input sample_type value, input logic is_null,
                              input logic last);
      int gap;
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample_value   <= value;
      req_sample_is_null <= is_null;
      req_record_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      calm = (sent_count >= calm_from);
   endtask

   // stop offering, wait for every predicted result, then let the block drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_half_length(input logic [HALF_W-1:0] h);
      csr_valid       <= 1'b1;
      csr_half_length <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random stall bursts, one long hold-off, none near the end
   initial begin : receiver
      int   span;
      bit   held;
      logic hold_value;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            hold_value = 1'b0;
            span       = 1;
         end else if (!held && sent_count >= LONG_HOLD_AT) begin
            held       = 1'b1;
            hold_value = 1'b1;
            span       = LONG_HOLD_CYCLES;
         end else if ($urandom_range(0, 2) == 0) begin
            hold_value = 1'b1;
            span       = $urandom_range(1, 12);
         end else begin
            hold_value = 1'b0;
            span       = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
         end
         rsp_stall <= hold_value;
         repeat (span - 1) @(posedge clock);
      end
   end

   initial begin : stimulus
      int         stop_at;
      int         h;
      int         records;
      int         length;
      int         null_pct;
      int         value_mode;
      sample_type value;
      logic       is_null;

      sent_count         = 0;
      calm_from          = 32'h7fff_ffff;
      calm               = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sample_value   = '0;
      req_sample_is_null = 1'b0;
      req_record_last    = 1'b0;
      csr_valid          = 1'b0;
      csr_half_length    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero half length passes samples through, field extremes
      write_half_length(HALF_W'(0));
      send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
      send_sample(32'sh8000_0000, 1'b0, 1'b0);
      send_sample(32'sh1234_5678, 1'b1, 1'b0);
      send_sample(0, 1'b0, 1'b0);
      send_sample(-1, 1'b0, 1'b1);
      settle();

      // record of nulls only gives null windows
      write_half_length(HALF_W'(2));
      send_sample(5, 1'b1, 1'b0);
      send_sample(-5, 1'b1, 1'b0);
      send_sample(9, 1'b1, 1'b0);
      send_sample(0, 1'b1, 1'b1);

      // one-sample record
      send_sample(-77, 1'b0, 1'b1);

      // half length changed in the middle of a record
      send_sample(100, 1'b0, 1'b0);
      send_sample(-100, 1'b0, 1'b0);
      send_sample(32'sh8000_0000, 1'b0, 1'b0);
      send_sample(3, 1'b1, 1'b0);
      settle();
      write_half_length(HALF_W'(1));
      send_sample(32'sh7fff_ffff, 1'b0, 1'b0);
      send_sample(3, 1'b0, 1'b0);
      send_sample(3, 1'b0, 1'b1);
      settle();

      // record shorter than the half window at full length
      write_half_length(HALF_W'(MAX_HALF));
      send_sample(10, 1'b0, 1'b0);
      send_sample(-20, 1'b1, 1'b0);
      send_sample(30, 1'b0, 1'b1);

      // random records, half length changed between groups of records
      stop_at   = sent_count + RANDOM_ITEMS;
      calm_from = stop_at - CALM_ITEMS;
      while (sent_count < stop_at) begin
         settle();
         case ($urandom_range(0, 5))
            0:       h = 0;
            1:       h = MAX_HALF;
            default: h = $urandom_range(0, MAX_HALF);
         endcase
         write_half_length(HALF_W'(h));
         records = $urandom_range(1, 4);
         for (int r = 0; r < records && sent_count < stop_at; r++) begin
            length = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 45)
                                                 : $urandom_range(1, 2 * h + 4);
            case ($urandom_range(0, 7))
               0:       null_pct = 100;
               1, 2:    null_pct = 80;
               3, 4:    null_pct = 25;
               default: null_pct = 0;
            endcase
            value_mode = $urandom_range(0, 3);
            for (int i = 0; i < length; i++) begin
               case (value_mode)
                  // narrow range so ties are common
                  0: begin
                     value = $urandom_range(0, 16);
                     value = value - 8;
                  end
                  // extremes mixed with random values
                  1: begin
                     case ($urandom_range(0, 4))
                        0:       value = 32'sh7fff_ffff;
                        1:       value = 32'sh8000_0000;
                        2:       value = 0;
                        3:       value = -1;
                        default: value = $urandom;
                     endcase
                  end
                  default: value = $urandom;
               endcase
               is_null = ($urandom_range(1, 100) <= null_pct);
               send_sample(value, is_null, i == length - 1);
            end
         end
      end

      settle();
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
